// ----- hw/rtl/pirtq_pkg.sv -----
// shared constants and types for the point in rectangle table query unit
`timescale 1ns / 1ps

package pirtq_pkg;

	localparam int MAX_RECTS = 64;
	localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W = $clog2(MAX_RECTS + 1);

	localparam int KIND_W = 2;
	localparam int COORD_W = 16;
	localparam int EDGE_W = 17;
	localparam int SIZE_W = 15;
	localparam int TAG_W = 32;
	localparam int HIT_INDEX_W = 6;

	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 104;
	localparam int M_TUSER_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [EDGE_W-1:0]  right;
		logic [EDGE_W-1:0]  bottom;
		logic [TAG_W-1:0]   tag;
	} rect_t;

	typedef struct packed {
		logic                   hit;
		logic                   status;
		logic [HIT_INDEX_W-1:0] index;
		logic [COORD_W-1:0]     left;
		logic [COORD_W-1:0]     top;
		logic [SIZE_W-1:0]      width;
		logic [SIZE_W-1:0]      height;
		logic [TAG_W-1:0]       tag;
	} result_t;

endpackage

// ----- hw/rtl/point_in_rect_table_query_unit.sv -----
// top level of the point in rectangle table query unit
`timescale 1ns / 1ps
// Holds a table of up to MAX_RECTS rectangles and answers point hit tests.
// Input channel s_*: tuser carries the command kind (clear, append, query),
// tdata carries the point or rectangle and its tag. Output channel m_*:
// exactly one result transfer for every input transfer, in order; tuser has
// the hit and table-full flags, tdata the matching rectangle or zeros.
// Clear, append, an unused kind and a query on an empty table go from idle
// straight to the flush state, which moves the result into the output
// register once that is free. A query first passes through the scan state:
// it reads one table entry per cycle from a single-port synchronous memory
// and stops at the first covering entry or after the last stored entry, so
// it reads at most the current entry count (MAX_RECTS = 64 when full), and
// then goes to flush. New input is taken only in the idle state.
// One item is worked on at a time; the next input is taken as soon as the
// result sits in the output register, even while that result is stalled.
// If the receiver stalls, a finished result waits in an internal holding
// register and no further input is taken until it moves on.
// Reset empties the table (entry count to zero) and drops any pending result;
// the table memory itself is not cleared.
module point_in_rect_table_query_unit
	import pirtq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pos_x, pos_y, size_w, size_h, tag_in, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hit_index, hit_left, hit_top, hit_width, hit_height, hit_tag, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// hit, status
	output logic [M_TUSER_W-1:0] m_tuser
);

	state_t state_q, state_next;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_addr_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               pend_s1;
	rect_t              rd_data_s1;
	rect_t              rect_mem_q [MAX_RECTS];

	logic [COORD_W-1:0] px_q, py_q;
	result_t            res_q, out_q;
	logic               m_tvalid_q;

	logic               in_xfer;
	logic               out_free;
	logic               scan_hit;
	logic               scan_last;
	logic               scan_done;
	logic               rd_issue;
	logic               table_full;

	logic [COORD_W-1:0] in_x, in_y;
	logic [SIZE_W-1:0]  in_w, in_h;
	logic [TAG_W-1:0]   in_tag;
	kind_t              in_kind;
	logic [EDGE_W-1:0]  px_ext, py_ext;
	rect_t              wr_rect;
	logic [EDGE_W-1:0]  width_full, height_full;
	result_t            in_res;

	assign in_x    = s_tdata[15:0];
	assign in_y    = s_tdata[31:16];
	assign in_w    = s_tdata[46:32];
	assign in_h    = s_tdata[61:47];
	assign in_tag  = s_tdata[93:62];
	assign in_kind = kind_t'(s_tuser[KIND_W-1:0]);

	assign in_xfer    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign table_full = (cnt_q >= CNT_W'(MAX_RECTS));

	assign px_ext = {px_q[COORD_W-1], px_q};
	assign py_ext = {py_q[COORD_W-1], py_q};

	assign scan_hit = pend_s1
		&& ($signed(px_ext) >= $signed({rd_data_s1.left[COORD_W-1], rd_data_s1.left}))
		&& ($signed(px_ext) <= $signed(rd_data_s1.right))
		&& ($signed(py_ext) >= $signed({rd_data_s1.top[COORD_W-1], rd_data_s1.top}))
		&& ($signed(py_ext) <= $signed(rd_data_s1.bottom));
	assign scan_last = pend_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == cnt_q);
	assign scan_done = (state_q == ST_SCAN) && (scan_hit || scan_last);
	assign rd_issue  = (state_q == ST_SCAN) && (rd_addr_q < cnt_q) && !scan_done;

	assign wr_rect.left   = in_x;
	assign wr_rect.top    = in_y;
	assign wr_rect.right  = EDGE_W'($signed({in_x[COORD_W-1], in_x}) + $signed({2'b00, in_w}));
	assign wr_rect.bottom = EDGE_W'($signed({in_y[COORD_W-1], in_y}) + $signed({2'b00, in_h}));
	assign wr_rect.tag    = in_tag;

	assign width_full  = rd_data_s1.right
		- {rd_data_s1.left[COORD_W-1], rd_data_s1.left};
	assign height_full = rd_data_s1.bottom
		- {rd_data_s1.top[COORD_W-1], rd_data_s1.top};

	// starting result of a new item
	always_comb begin
		in_res        = '0;
		in_res.status = (in_kind == KIND_APPEND) && table_full;
	end

	// control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		s_tready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_kind == KIND_QUERY && cnt_q != '0) begin
						state_next = ST_SCAN;
					end else begin
						state_next = ST_FLUSH;
					end
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_next = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// table memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (in_xfer && in_kind == KIND_APPEND && !table_full) begin
			rect_mem_q[cnt_q[IDX_W-1:0]] <= wr_rect;
		end
		if (rd_issue) begin
			rd_data_s1 <= rect_mem_q[rd_addr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rd_addr_q  <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_issue;
			if (rd_issue) begin
				rd_addr_q <= rd_addr_q + CNT_W'(1);
			end
			if (in_xfer) begin
				rd_addr_q <= '0;
				if (in_kind == KIND_CLEAR) begin
					cnt_q <= '0;
				end else if (in_kind == KIND_APPEND && !table_full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_FLUSH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item, result and output payload
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1 <= rd_addr_q[IDX_W-1:0];
		end
		if (in_xfer) begin
			px_q  <= in_x;
			py_q  <= in_y;
			res_q <= in_res;
		end
		if (state_q == ST_SCAN && scan_hit) begin
			res_q.hit    <= 1'b1;
			res_q.index  <= HIT_INDEX_W'(idx_s1);
			res_q.left   <= rd_data_s1.left;
			res_q.top    <= rd_data_s1.top;
			res_q.width  <= width_full[SIZE_W-1:0];
			res_q.height <= height_full[SIZE_W-1:0];
			res_q.tag    <= rd_data_s1.tag;
		end
		if (state_q == ST_FLUSH && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {out_q.status, out_q.hit};
	assign m_tdata  = {4'b0000, out_q.tag, out_q.height, out_q.width,
		out_q.top, out_q.left, out_q.index};

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RECTS))
		else $error("entry count above table size");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit result flagged as dropped append");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (CNT_W'(idx_s1) < cnt_q))
		else $error("scan read beyond stored entries");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q != '0)
		else $error("scan on empty table");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> state_q == ST_FLUSH && !pend_s1)
		else $error("read still pending after scan end");
`endif

endmodule

// ----- tb/sv/tb_point_in_rect_table_query_unit.sv -----
// self-checking random testbench for the point in rectangle table query unit
`timescale 1ns / 1ps

module tb_point_in_rect_table_query_unit;
	import pirtq_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 800;
	localparam int RECV_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} box_t;

	class rect_hit_predictor;
		int left_edge[MAX_RECTS];
		int top_edge[MAX_RECTS];
		int right_edge[MAX_RECTS];
		int bottom_edge[MAX_RECTS];
		logic [TAG_W-1:0] tag_store[MAX_RECTS];
		int entry_count;
		result_t pending_hits[$];
		int mismatches;
		int n_clear, n_append, n_dropped, n_query, n_hit, n_unused;

		function new();
			entry_count = 0;
			mismatches = 0;
			n_clear = 0;
			n_append = 0;
			n_dropped = 0;
			n_query = 0;
			n_hit = 0;
			n_unused = 0;
		endfunction

		function void note_item(input logic [1:0] kind, input logic signed [15:0] px, py,
			input logic [14:0] w, h, input logic [31:0] tag);
			result_t r;
			int x, y, diff;
			r = '0;
			x = px;
			y = py;
			case (kind)
				KIND_CLEAR: begin
					entry_count = 0;
					n_clear++;
				end
				KIND_APPEND: begin
					n_append++;
					if (entry_count >= MAX_RECTS) begin
						r.status = 1'b1;
						n_dropped++;
					end else begin
						left_edge[entry_count] = x;
						top_edge[entry_count] = y;
						right_edge[entry_count] = x + int'(w);
						bottom_edge[entry_count] = y + int'(h);
						tag_store[entry_count] = tag;
						entry_count++;
					end
				end
				KIND_QUERY: begin
					n_query++;
					for (int i = 0; i < entry_count && !r.hit; i++) begin
						if (x >= left_edge[i] && x <= right_edge[i] &&
							y >= top_edge[i] && y <= bottom_edge[i]) begin
							r.hit = 1'b1;
							r.index = i[HIT_INDEX_W-1:0];
							r.left = left_edge[i][15:0];
							r.top = top_edge[i][15:0];
							diff = right_edge[i] - left_edge[i];
							r.width = diff[14:0];
							diff = bottom_edge[i] - top_edge[i];
							r.height = diff[14:0];
							r.tag = tag_store[i];
						end
					end
					if (r.hit)
						n_hit++;
				end
				default: begin
					n_unused++;
				end
			endcase
			pending_hits = {pending_hits, r};
		endfunction

		function void check_result(input logic [M_TUSER_W-1:0] tuser,
			input logic [M_TDATA_W-1:0] tdata);
			result_t got, want;
			string bad;
			got.hit = tuser[0];
			got.status = tuser[1];
			got.index = tdata[5:0];
			got.left = tdata[21:6];
			got.top = tdata[37:22];
			got.width = tdata[52:38];
			got.height = tdata[67:53];
			got.tag = tdata[99:68];
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result transfer with nothing expected", $time);
				return;
			end
			want = pending_hits.pop_front();
			bad = "";
			if (got.hit !== want.hit) bad = {bad, " hit"};
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.index !== want.index) bad = {bad, " index"};
			if (got.left !== want.left) bad = {bad, " left"};
			if (got.top !== want.top) bad = {bad, " top"};
			if (got.width !== want.width) bad = {bad, " width"};
			if (got.height !== want.height) bad = {bad, " height"};
			if (got.tag !== want.tag) bad = {bad, " tag"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: mismatch in%s", $time, bad);
					$display("  expected hit=%b status=%b idx=%0d l=%0d t=%0d w=%0d h=%0d tag=%h",
						want.hit, want.status, want.index, $signed(want.left),
						$signed(want.top), want.width, want.height, want.tag);
					$display("  actual   hit=%b status=%b idx=%0d l=%0d t=%0d w=%0d h=%0d tag=%h",
						got.hit, got.status, got.index, $signed(got.left),
						$signed(got.top), got.width, got.height, got.tag);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	rect_hit_predictor predictor;
	box_t session_boxes[$];
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_request = 1'b0;

	point_in_rect_table_query_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [1:0] kind, input logic signed [15:0] px, py,
		input logic [14:0] w, h, input logic [31:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, tag, h, w, py, px};
		do
			@(posedge clk);
		while (!s_tready);
		predictor.note_item(kind, px, py, w, h, tag);
		items_sent++;
	endtask

	function automatic int wide_coord();
		case ($urandom_range(3))
			0: return -32768;
			1: return 32767;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic int wide_size();
		case ($urandom_range(3))
			0: return 0;
			1: return 32767;
			default: return int'($urandom_range(32767));
		endcase
	endfunction

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic send_other(input logic [1:0] kind, input int x, input int y);
		logic [31:0] r;
		r = $urandom;
		send_item(kind, x[15:0], y[15:0], r[14:0], r[29:15], $urandom);
	endtask

	task automatic probe(input int x, input int y);
		send_other(KIND_QUERY, x, y);
	endtask

	task automatic wipe();
		send_other(KIND_CLEAR, wide_coord(), wide_coord());
		session_boxes.delete();
	endtask

	task automatic put_box(input int x, input int y, input int w, input int h,
		input logic [31:0] tag);
		box_t b;
		b.x = x;
		b.y = y;
		b.w = w;
		b.h = h;
		send_item(KIND_APPEND, x[15:0], y[15:0], w[14:0], h[14:0], tag);
		if (session_boxes.size() < MAX_RECTS)
			session_boxes = {session_boxes, b};
	endtask

	task automatic put_random_box();
		int x, y, w, h;
		logic [31:0] tag;
		if ($urandom_range(4) == 0) begin
			x = wide_coord();
			y = wide_coord();
			w = wide_size();
			h = wide_size();
		end else begin
			x = int'($urandom_range(400)) - 200;
			y = int'($urandom_range(400)) - 200;
			w = $urandom_range(60);
			h = $urandom_range(60);
		end
		tag = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
		put_box(x, y, w, h, tag);
	endtask

	// points on corners, edges, inside or one step outside a stored box, else a random point
	task automatic aim_query();
		box_t b;
		int lo_x, hi_x, lo_y, hi_y, x, y;
		if (session_boxes.size() == 0 || $urandom_range(3) == 0) begin
			if ($urandom_range(1) == 0)
				probe(wide_coord(), wide_coord());
			else
				probe(int'($urandom_range(460)) - 230, int'($urandom_range(460)) - 230);
			return;
		end
		b = session_boxes[$urandom_range(session_boxes.size() - 1)];
		lo_x = b.x;
		hi_x = b.x + b.w;
		lo_y = b.y;
		hi_y = b.y + b.h;
		x = lo_x + int'($urandom_range(b.w));
		y = lo_y + int'($urandom_range(b.h));
		case ($urandom_range(5))
			0: begin
				x = $urandom_range(1) ? hi_x : lo_x;
				y = $urandom_range(1) ? hi_y : lo_y;
			end
			1: x = $urandom_range(1) ? hi_x + 1 : lo_x - 1;
			2: y = $urandom_range(1) ? hi_y + 1 : lo_y - 1;
			3: x = $urandom_range(1) ? hi_x : lo_x;
			default: ;
		endcase
		probe(clamp16(x), clamp16(y));
	endtask

	task automatic run_session(input bit fill);
		int n_rects, n_queries;
		if (fill || $urandom_range(4) != 0)
			wipe();
		n_rects = fill ? $urandom_range(70, 64) : $urandom_range(12, 1);
		repeat (n_rects) begin
			put_random_box();
			if ($urandom_range(5) == 0)
				aim_query();
		end
		n_queries = $urandom_range(10, 3);
		repeat (n_queries) begin
			if ($urandom_range(19) == 0)
				send_other(KIND_UNUSED, wide_coord(), wide_coord());
			else
				aim_query();
		end
	endtask

	task automatic run_directed();
		probe(0, 0);
		put_box(-32768, -32768, 32767, 32767, 32'hffff_ffff);
		put_box(32767, 32767, 32767, 32767, 32'd0);
		probe(32767, 32767);
		probe(-32768, -32768);
		probe(-1, -1);
		probe(0, 0);
		probe(-32768, 0);
		put_box(5, 5, 0, 0, 32'h1234_5678);
		probe(5, 5);
		probe(6, 5);
		probe(5, 4);
		put_box(0, 0, 10, 10, 32'hdead_beef);
		probe(5, 5);
		probe(10, 10);
		probe(11, 10);
		probe(0, -1);
		send_item(KIND_UNUSED, -16'sd1, -16'sd1, 15'h7fff, 15'h7fff, 32'hffff_ffff);
		probe(5, 5);
		wipe();
		probe(5, 5);
		probe(-1, -1);
		put_box(-100, 50, 1, 32767, 32'h0000_0001);
		probe(-99, 32767);
	endtask

	// result side: checks transfers and drives tready, with one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				predictor.check_result(m_tuser, m_tdata);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left = RECV_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int base, done;
		bit pressed, first;
		predictor = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 54;
		run_directed();

		base = items_sent;
		pressed = 1'b0;
		first = 1'b1;
		while (items_sent - base < RANDOM_ITEMS) begin
			done = items_sent - base;
			if (done < RANDOM_ITEMS / 3) begin
				send_idle_pct = 15;
				recv_idle_pct = 54;
			end else if (done < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				if (!pressed) begin
					pressed = 1'b1;
					stall_request = 1'b1;
					first = 1'b1;
				end
			end
			run_session(first);
			first = 1'b0;
		end
		s_tvalid <= 1'b0;

		while (predictor.pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d clears, %0d appends (%0d dropped, table full), %0d unused",
			items_sent, predictor.n_clear, predictor.n_append, predictor.n_dropped,
			predictor.n_unused);
		$display("%0d point queries with %0d hits and %0d misses, %0d mismatches",
			predictor.n_query, predictor.n_hit, predictor.n_query - predictor.n_hit,
			predictor.mismatches);
		if (predictor.mismatches == 0 && predictor.pending_hits.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/pirtq_pkg.sv
hw/rtl/point_in_rect_table_query_unit.sv
tb/sv/tb_point_in_rect_table_query_unit.sv
